[src/ternary_lut_matvec_accumulator_assert.svh]
// assertion macros shared by the checker
`ifndef TERNARY_LUT_MATVEC_ACCUMULATOR_ASSERT_SVH
`define TERNARY_LUT_MATVEC_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define TLMA_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ternary lut accumulator check failed");

// next-cycle implication
`define TLMA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ternary lut accumulator check failed");

`endif

[src/tlma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tlma_pkg;

   localparam int LANES      = 16;
   localparam int COLUMNS    = 256;
   localparam int CODES      = 256;
   localparam int LANE_BITS  = 4;
   localparam int COL_BITS   = 8;
   localparam int CODE_BITS  = 8;
   localparam int ADDR_BITS  = LANE_BITS + COL_BITS;
   localparam int DEPTH      = LANES * COLUMNS;
   localparam int CNT_BITS   = ADDR_BITS + 1;
   localparam int TRIT_CODES = 81;
   localparam int TRIT_BIAS  = 40;

   typedef logic signed [7:0]  act_type;
   typedef logic signed [15:0] part_type;
   typedef logic signed [31:0] total_type;

   typedef enum logic [2:0] {
      CMD_LOAD   = 3'd0,
      CMD_ACCUM  = 3'd1,
      CMD_FLUSH  = 3'd2,
      CMD_READ   = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FILL,
      ST_ACCUM,
      ST_FLUSH,
      ST_CLEAR,
      ST_READ,
      ST_SKIP
   } state_type;

   // base-three code to two-bit-per-weight table index, out of range gives zero
   function automatic logic [CODE_BITS-1:0] trit_to_pairs(input logic [CODE_BITS-1:0] code);
      logic [CODE_BITS-1:0] idx;
      int                   val;
      idx = '0;
      for (int d3 = 0; d3 < 3; d3++) begin
         for (int d2 = 0; d2 < 3; d2++) begin
            for (int d1 = 0; d1 < 3; d1++) begin
               for (int d0 = 0; d0 < 3; d0++) begin
                  val = d0 + 3 * d1 + 9 * d2 + 27 * d3;
                  if (int'(code) == val) begin
                     idx = {(d3 == 2) ? 2'b01 : ((d3 == 0) ? 2'b11 : 2'b00),
                            (d2 == 2) ? 2'b01 : ((d2 == 0) ? 2'b11 : 2'b00),
                            (d1 == 2) ? 2'b01 : ((d1 == 0) ? 2'b11 : 2'b00),
                            (d0 == 2) ? 2'b01 : ((d0 == 0) ? 2'b11 : 2'b00)};
                  end
               end
            end
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

[src/ternary_lut_matvec_accumulator.sv]
`timescale 1ns / 1ps
// one item at a time: ready only while idle, so no new item is taken until the last one's sweep ends
// load: 256 table entries written one per cycle, accumulate: one lane per cycle through the
// shared 16-bit adder, flush and clear: one sweep over all lanes and columns
// read: the total memory read is registered, then the result register; a result stall holds the sequencer busy
// unknown commands pass through a skip state; synchronous reset, then a clearing pass over
// partials and totals before the first item is taken (configuration writes still taken)
`default_nettype none
module ternary_lut_matvec_accumulator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // command[2:0], lane[6:3], act_zero[14:7], act_one[22:15], act_two[30:23],
   // act_three[38:31], column[46:39], weight_code[54:47], zero[55]
   input  wire logic [55:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // total_value[31:0], read_lane[35:32], read_column[43:36], zero[47:44]
   output      logic [47:0] rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   tlma_pkg::state_type state_ff, state_in;
   logic [tlma_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [tlma_pkg::CNT_BITS-1:0]  len;
   logic                           format_ff;
   logic [tlma_pkg::LANE_BITS-1:0] lane_ff;
   logic [tlma_pkg::COL_BITS-1:0]  col_ff;
   logic [tlma_pkg::CODE_BITS-1:0] idx_ff;
   tlma_pkg::act_type              act_ff [4];
   logic                           pipe_ff, pipe_in;
   logic [tlma_pkg::ADDR_BITS-1:0] paddr_ff, paddr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [47:0]                    rsp_data_ff;

   // memories
   tlma_pkg::part_type  table_mem [tlma_pkg::DEPTH];
   tlma_pkg::part_type  part_mem  [tlma_pkg::DEPTH];
   tlma_pkg::total_type tot_mem   [tlma_pkg::DEPTH];
   tlma_pkg::part_type  table_rd_ff, part_rd_ff;
   tlma_pkg::total_type tot_rd_ff;
   logic [tlma_pkg::ADDR_BITS-1:0] table_ra, part_ra, tot_ra;
   logic [tlma_pkg::ADDR_BITS-1:0] table_wa, part_wa, tot_wa;
   logic                           table_we, part_we, tot_we;
   tlma_pkg::part_type             table_wd, part_wd;
   tlma_pkg::total_type            tot_wd;

   logic                           accept, issue, done;
   logic [tlma_pkg::CODE_BITS-1:0] fill_idx;
   logic signed [10:0]             fill_sum;
   tlma_pkg::cmd_type              cmd;

   assign accept   = req_tvalid && req_tready;
   assign cmd      = tlma_pkg::cmd_type'(req_tdata[2:0]);
   assign fill_idx = cnt_ff[tlma_pkg::CODE_BITS-1:0];

   // sweep length per state
   always_comb begin
      case (state_ff)
         tlma_pkg::ST_FILL:  len = tlma_pkg::CNT_BITS'(tlma_pkg::CODES);
         tlma_pkg::ST_ACCUM: len = tlma_pkg::CNT_BITS'(tlma_pkg::LANES);
         tlma_pkg::ST_INIT, tlma_pkg::ST_FLUSH, tlma_pkg::ST_CLEAR:
            len = tlma_pkg::CNT_BITS'(tlma_pkg::DEPTH);
         tlma_pkg::ST_READ:  len = tlma_pkg::CNT_BITS'(1);
         default:            len = '0;
      endcase
   end

   assign issue = (cnt_ff < len);
   assign done  = !issue;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlma_pkg::ST_INIT, tlma_pkg::ST_FILL, tlma_pkg::ST_ACCUM, tlma_pkg::ST_FLUSH,
         tlma_pkg::ST_CLEAR: begin
            if (done) state_in = tlma_pkg::ST_IDLE;
         end
         tlma_pkg::ST_READ: begin
            if (done && (!rsp_valid_ff || rsp_tready)) state_in = tlma_pkg::ST_IDLE;
         end
         tlma_pkg::ST_SKIP: state_in = tlma_pkg::ST_IDLE;
         tlma_pkg::ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  tlma_pkg::CMD_LOAD:  state_in = tlma_pkg::ST_FILL;
                  tlma_pkg::CMD_ACCUM: state_in = tlma_pkg::ST_ACCUM;
                  tlma_pkg::CMD_FLUSH: state_in = tlma_pkg::ST_FLUSH;
                  tlma_pkg::CMD_READ:  state_in = tlma_pkg::ST_READ;
                  tlma_pkg::CMD_CLEAR: state_in = tlma_pkg::ST_CLEAR;
                  default:             state_in = tlma_pkg::ST_SKIP;
               endcase
            end
         end
         default: state_in = tlma_pkg::ST_IDLE;
      endcase
   end

   // table entry sum for the fill sweep
   always_comb begin
      fill_sum = '0;
      for (int k = 0; k < 4; k++) begin
         case (fill_idx[2*k +: 2])
            2'b01:   fill_sum = fill_sum + 11'(act_ff[k]);
            2'b11:   fill_sum = fill_sum - 11'(act_ff[k]);
            default: fill_sum = fill_sum;
         endcase
      end
   end

   // sequencer outputs: counter, ready, addresses, writes, result valid
   always_comb begin
      cnt_in       = (state_ff == tlma_pkg::ST_IDLE) ? '0
                                                     : cnt_ff + tlma_pkg::CNT_BITS'(issue);
      pipe_in      = 1'b0;
      paddr_in     = paddr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = (state_ff == tlma_pkg::ST_IDLE);
      table_ra     = {cnt_ff[tlma_pkg::LANE_BITS-1:0], idx_ff};
      part_ra      = {cnt_ff[tlma_pkg::LANE_BITS-1:0], col_ff};
      tot_ra       = {lane_ff, col_ff};
      table_we     = 1'b0;
      table_wa     = {lane_ff, fill_idx};
      table_wd     = tlma_pkg::part_type'(fill_sum);
      part_we      = 1'b0;
      part_wa      = paddr_ff;
      part_wd      = part_rd_ff + table_rd_ff;
      tot_we       = 1'b0;
      tot_wa       = paddr_ff;
      tot_wd       = tot_rd_ff + 32'(part_rd_ff);
      case (state_ff)
         tlma_pkg::ST_INIT: begin
            part_we = issue;
            part_wa = cnt_ff[tlma_pkg::ADDR_BITS-1:0];
            part_wd = '0;
            tot_we  = issue;
            tot_wa  = cnt_ff[tlma_pkg::ADDR_BITS-1:0];
            tot_wd  = '0;
         end
         tlma_pkg::ST_FILL: table_we = issue;
         tlma_pkg::ST_ACCUM: begin
            pipe_in  = issue;
            paddr_in = part_ra;
            part_we  = pipe_ff;
         end
         tlma_pkg::ST_FLUSH: begin
            part_ra  = cnt_ff[tlma_pkg::ADDR_BITS-1:0];
            tot_ra   = cnt_ff[tlma_pkg::ADDR_BITS-1:0];
            pipe_in  = issue;
            paddr_in = cnt_ff[tlma_pkg::ADDR_BITS-1:0];
            part_we  = pipe_ff;
            part_wd  = '0;
            tot_we   = pipe_ff;
         end
         tlma_pkg::ST_CLEAR: begin
            tot_we = issue;
            tot_wa = cnt_ff[tlma_pkg::ADDR_BITS-1:0];
            tot_wd = '0;
         end
         tlma_pkg::ST_READ: begin
            if (done && (!rsp_valid_ff || rsp_tready)) rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlma_pkg::ST_INIT;
         cnt_ff       <= '0;
         pipe_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         format_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pipe_ff      <= pipe_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) format_ff <= csr_wr_data;
      end
   end

   // item fields, pipeline address and result data
   always_ff @(posedge clock) begin
      paddr_ff <= paddr_in;
      if (accept) begin
         lane_ff   <= req_tdata[6:3];
         act_ff[0] <= req_tdata[14:7];
         act_ff[1] <= req_tdata[22:15];
         act_ff[2] <= req_tdata[30:23];
         act_ff[3] <= req_tdata[38:31];
         col_ff    <= req_tdata[46:39];
         idx_ff    <= format_ff ? req_tdata[54:47]
                                : tlma_pkg::trit_to_pairs(req_tdata[54:47]);
      end
      if (state_ff == tlma_pkg::ST_READ && !rsp_valid_ff || rsp_tready && rsp_valid_in
          && !rsp_valid_ff) begin
         rsp_data_ff <= {4'b0000, col_ff, lane_ff, tot_rd_ff};
      end else if (state_ff == tlma_pkg::ST_READ && done && rsp_tready) begin
         rsp_data_ff <= {4'b0000, col_ff, lane_ff, tot_rd_ff};
      end
   end

   // lookup table memory
   always_ff @(posedge clock) begin
      if (table_we) table_mem[table_wa] <= table_wd;
      table_rd_ff <= table_mem[table_ra];
   end

   // partial sum memory
   always_ff @(posedge clock) begin
      if (part_we) part_mem[part_wa] <= part_wd;
      part_rd_ff <= part_mem[part_ra];
   end

   // total memory
   always_ff @(posedge clock) begin
      if (tot_we) tot_mem[tot_wa] <= tot_wd;
      tot_rd_ff <= tot_mem[tot_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

[src/tlma_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ternary_lut_matvec_accumulator_assert.svh"
module tlma_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // stalled result holds
   `TLMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // the sequencer is busy in the cycle after each transfer
   `TLMA_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_tvalid && req_tready, !req_tready)
   // clearing pass after reset blocks input
   `TLMA_ASSERT_NOW(a_init_blocks, clock, reset, $past(reset), !req_tready)
   // no result straight out of reset
   `TLMA_ASSERT_NOW(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid)

endmodule

bind ternary_lut_matvec_accumulator tlma_checker u_tlma_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

[dv/ternary_lut_matvec_accumulator_tb.sv]
`timescale 1ns / 1ps
module ternary_lut_matvec_accumulator_tb;

   // expected totals, mirror of the lane tables, partial sums and totals
   class total_scoreboard;
      logic signed [15:0] lane_table [tlma_pkg::LANES][tlma_pkg::CODES];
      logic signed [15:0] partial [tlma_pkg::LANES][tlma_pkg::COLUMNS];
      logic signed [31:0] total [tlma_pkg::LANES][tlma_pkg::COLUMNS];
      logic               fmt;
      logic [47:0]        expected_reads [$];
      int                 errors;

      function new();
         foreach (partial[r, c]) begin
            partial[r][c] = '0;
            total[r][c] = '0;
         end
         foreach (lane_table[r, i]) lane_table[r][i] = '0;
         fmt = 1'b0;
         errors = 0;
      endfunction

      // base-three code to two bits per weight
      function logic [7:0] trit_index(logic [7:0] code);
         logic [7:0] idx;
         int         rest;
         int         digit;
         idx = '0;
         rest = code;
         if (code >= tlma_pkg::TRIT_CODES) return '0;
         for (int k = 0; k < 4; k++) begin
            digit = rest % 3;
            rest = rest / 3;
            if (digit == 2) idx[2*k +: 2] = 2'b01;
            else if (digit == 0) idx[2*k +: 2] = 2'b11;
         end
         return idx;
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      // apply one accepted transfer to the mirror state
      function void note_input(logic [55:0] d);
         logic [2:0]  cmd;
         logic [3:0]  ln;
         logic [7:0]  col;
         logic [7:0]  code;
         logic [7:0]  idx;
         int          acc;
         logic signed [7:0] act [4];
         cmd = d[2:0];
         ln = d[6:3];
         col = d[46:39];
         code = d[54:47];
         for (int k = 0; k < 4; k++) act[k] = d[7 + 8*k +: 8];
         case (cmd)
            tlma_pkg::CMD_LOAD: begin
               for (int i = 0; i < tlma_pkg::CODES; i++) begin
                  acc = 0;
                  for (int k = 0; k < 4; k++) begin
                     if (i[2*k +: 2] == 2'b01) acc += act[k];
                     else if (i[2*k +: 2] == 2'b11) acc -= act[k];
                  end
                  lane_table[ln][i] = acc[15:0];
               end
            end
            tlma_pkg::CMD_ACCUM: begin
               idx = fmt ? code : trit_index(code);
               for (int r = 0; r < tlma_pkg::LANES; r++)
                  partial[r][col] = partial[r][col] + lane_table[r][idx];
            end
            tlma_pkg::CMD_FLUSH: begin
               foreach (partial[r, c]) begin
                  total[r][c] = total[r][c] + 32'(partial[r][c]);
                  partial[r][c] = '0;
               end
            end
            tlma_pkg::CMD_READ: expected_reads.push_back({4'b0, col, ln, total[ln][col]});
            tlma_pkg::CMD_CLEAR: foreach (total[r, c]) total[r][c] = '0;
            default: ;
         endcase
      endfunction

      task check_result(logic [47:0] got);
         logic [47:0] want;
         if (expected_reads.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = expected_reads.pop_front();
         if (got[31:0] !== want[31:0])
            report($sformatf("total %0d, want %0d", $signed(got[31:0]), $signed(want[31:0])));
         if (got[35:32] !== want[35:32])
            report($sformatf("lane %0d, want %0d", got[35:32], want[35:32]));
         if (got[43:36] !== want[43:36])
            report($sformatf("column %0d, want %0d", got[43:36], want[43:36]));
         if (got[47:44] !== 4'b0) report("pad bits not zero");
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        hold_off;

   total_scoreboard sb;

   ternary_lut_matvec_accumulator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("ternary_lut_matvec_accumulator test failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function logic [55:0] pack_item(tlma_pkg::cmd_type cmd, logic [3:0] ln, logic [31:0] acts,
                                   logic [7:0] col, logic [7:0] code);
      return {1'b0, code, col, acts, ln, 3'(cmd)};
   endfunction

   // offer one item and hold it until the transfer
   task send(logic [55:0] d);
      int n;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_input(d);
      n = gap_len();
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tdata <= 56'({$urandom, $urandom});
      repeat (n) @(negedge clock);
   endtask

   task drain();
      while (sb.expected_reads.size() != 0) @(posedge clock);
      // items without a result may still be in progress
      repeat (4200) @(posedge clock);
   endtask

   task write_format(logic f);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= f;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.fmt = f;
   endtask

   function logic [31:0] rand_acts();
      logic [31:0] a;
      a = $urandom;
      for (int k = 0; k < 4; k++)
         case ($urandom_range(0, 7))
            0: a[8*k +: 8] = 8'h7f;
            1: a[8*k +: 8] = 8'h80;
            default: ;
         endcase
      return a;
   endfunction

   // one random item, weighted towards accumulates
   task random_item();
      int roll;
      logic [7:0] code;
      roll = $urandom_range(0, 999);
      code = (!sb.fmt && $urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 80)) : 8'($urandom);
      if (roll < 100)
         send(pack_item(tlma_pkg::CMD_LOAD, 4'($urandom), rand_acts(), 8'($urandom),
                        8'($urandom)));
      else if (roll < 720)
         send(pack_item(tlma_pkg::CMD_ACCUM, 4'($urandom), $urandom, 8'($urandom), code));
      else if (roll < 900)
         send(pack_item(tlma_pkg::CMD_READ, 4'($urandom), $urandom, 8'($urandom),
                        8'($urandom)));
      else if (roll < 950)
         send(pack_item(tlma_pkg::CMD_FLUSH, 4'($urandom), $urandom, 8'($urandom),
                        8'($urandom)));
      else if (roll < 962)
         send(pack_item(tlma_pkg::CMD_CLEAR, 4'($urandom), $urandom, 8'($urandom),
                        8'($urandom)));
      else
         send(56'({$urandom, $urandom}) & 56'h7f_ffff_ffff_fff8 | 56'($urandom_range(5, 7)));
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < 400; i++) @(negedge clock);
            hold_off = 1'b0;
         end
         if ($urandom_range(0, 99) < 12) begin
            rsp_tready <= 1'b0;
            repeat (gap_len()) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result transfers
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      hold_off = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_format(1'b0);

      // every lane loaded first, extremes on the first two
      send(pack_item(tlma_pkg::CMD_LOAD, 4'd0, 32'h7f7f_7f7f, 8'd0, 8'd0));
      send(pack_item(tlma_pkg::CMD_LOAD, 4'd1, 32'h8080_8080, 8'd0, 8'd0));
      for (int l = 2; l < tlma_pkg::LANES; l++)
         send(pack_item(tlma_pkg::CMD_LOAD, 4'(l), rand_acts(), 8'($urandom), 8'($urandom)));
      // all weights plus one, all minus one, codes out of range
      send(pack_item(tlma_pkg::CMD_ACCUM, 4'd0, '0, 8'd0, 8'd80));
      send(pack_item(tlma_pkg::CMD_ACCUM, 4'd0, '0, 8'd255, 8'd0));
      send(pack_item(tlma_pkg::CMD_ACCUM, 4'd0, '0, 8'd7, 8'd81));
      send(pack_item(tlma_pkg::CMD_ACCUM, 4'd0, '0, 8'd7, 8'd255));
      send(pack_item(tlma_pkg::CMD_FLUSH, 4'd0, '0, 8'd0, 8'd0));
      send(pack_item(tlma_pkg::CMD_READ, 4'd0, '0, 8'd0, 8'd0));
      send(pack_item(tlma_pkg::CMD_READ, 4'd1, '0, 8'd0, 8'd0));
      send(pack_item(tlma_pkg::CMD_READ, 4'd15, '0, 8'd255, 8'd0));
      send(pack_item(tlma_pkg::CMD_CLEAR, 4'd0, '0, 8'd0, 8'd0));
      send(pack_item(tlma_pkg::CMD_READ, 4'd1, '0, 8'd0, 8'd0));
      send({48'hffff_ffff_ffff, 8'hff});
      drain();

      // random phases across both weight formats
      for (int ph = 0; ph < 4; ph++) begin
         write_format(ph[0] ? 1'b0 : 1'b1);
         if (ph == 1) begin
            hold_off = 1'b1;
            repeat (6)
               send(pack_item(tlma_pkg::CMD_READ, 4'($urandom), $urandom, 8'($urandom),
                              8'($urandom)));
         end
         repeat (270) random_item();
         drain();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      if (sb.errors == 0)
         $display("ternary_lut_matvec_accumulator test passed");
      else
         $display("ternary_lut_matvec_accumulator test failed");
      $finish;
   end
endmodule
